/* design/serial_line_framer_assert.svh */
// Assertion macros shared by the line framer RTL.
`ifndef SERIAL_LINE_FRAMER_ASSERT_SVH
`define SERIAL_LINE_FRAMER_ASSERT_SVH

// Check that a condition implies a consequence in the same cycle.
`define SLF_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("serial_line_framer: same-cycle check failed");

// Check that a condition implies a consequence in the following cycle.
`define SLF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("serial_line_framer: next-cycle check failed");

`endif

/* design/slf_pkg.sv */
// Types and constants of the serial line framer.
package slf_pkg;

	// Request kinds
	localparam logic OP_BYTE = 1'b0;
	localparam logic OP_TICK = 1'b1;

	// Line terminators
	localparam logic [7:0] CH_LF = 8'h0A;
	localparam logic [7:0] CH_CR = 8'h0D;

	// Idle timeout after reset
	localparam logic [15:0] TIMEOUT_RESET = 16'd100;

	// Terminator that is holding the current line
	typedef enum logic [1:0] {
		PEND_NONE,
		PEND_CR,
		PEND_LF
	} pend_t;

	typedef struct packed {
		logic       op;
		logic [7:0] rx_byte;
	} in_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       line_binary;
		logic       last;
	} out_t;

endpackage

/* design/slf_line_mem.sv */
// Line store: one write port, one read port with registered read data.
module slf_line_mem #(
	parameter int DEPTH = 64,
	parameter int IDX_W = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [IDX_W-1:0] waddr,
	input  logic [7:0]       wdata,
	input  logic             re,
	input  logic [IDX_W-1:0] raddr,
	output logic [7:0]       rdata
);

	logic [7:0] mem_q [DEPTH];
	logic [7:0] data_s1;

	// Write one byte
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Read one byte, hold the result while no read is issued
	always_ff @(posedge clk) begin
		if (re) begin
			data_s1 <= mem_q[raddr];
		end
	end

	assign rdata = data_s1;

endmodule

/* design/serial_line_framer.sv */
// Top level of the serial line framer: sequencer, drain pipeline and output register.
//
// Requests are bytes or millisecond ticks. A request that only stores a byte or
// counts a tick does not stall the input. A request that flushes a line occupies
// the block while the drain sequencer steps through the single read port of the
// line store, one entry per cycle while the output does not stall; output stall
// holds the drain. A byte that follows a held line and starts a new one is written
// after the drain. in_stall is high while a drain or the write of such a byte is in
// progress. Results stream out one byte at a time on the output channel, each with
// the line's binary flag, the final byte marked with last. The idle timeout is
// written through cfg_we/cfg_wdata; the user must write it only while the block is
// idle, which the block itself does not enforce.
module serial_line_framer import slf_pkg::*; #(
	parameter int BUFFER_DEPTH = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  in_t         in_data,
	output logic        out_valid,
	input  logic        out_stall,
	output out_t        out_data,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata
);

	localparam int IDX_W = $clog2(BUFFER_DEPTH);
	localparam int CNT_W = $clog2(BUFFER_DEPTH + 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DRAIN,
		ST_APPEND
	} state_t;

	state_t           state_q;
	logic [CNT_W-1:0] fill_q;
	logic             bin_q;
	logic [15:0]      idle_q;
	pend_t            pend_q;
	logic [15:0]      timeout_q;
	logic [CNT_W-1:0] rd_idx_q;
	logic [CNT_W-1:0] len_q;
	logic             len_bin_q;
	logic             defer_q;
	logic [7:0]       held_byte_q;
	logic             rd_valid_s1;
	logic             rd_last_s1;
	logic             rd_bin_s1;
	logic             out_valid_q;
	out_t             out_q;

	logic             accept;
	logic             is_byte;
	logic [7:0]       rx;
	logic             is_term;
	logic             partner;
	logic             room;
	logic [CNT_W-1:0] fill_inc;
	logic             full_next;
	logic             start_drain;
	logic             start_defer;
	logic [CNT_W-1:0] start_len;
	logic             start_bin;
	logic             mem_we;
	logic [IDX_W-1:0] mem_waddr;
	logic [7:0]       mem_wdata;
	logic             rd_en;
	logic             rd_last;
	logic             s1_move;
	logic [7:0]       rd_data;
	logic             held_term;

	assign accept    = in_valid && (state_q == ST_IDLE);
	assign in_stall  = (state_q != ST_IDLE);
	assign is_byte   = (in_data.op == OP_BYTE);
	assign rx        = in_data.rx_byte;
	assign is_term   = (rx == CH_CR) || (rx == CH_LF);
	assign partner   = ((pend_q == PEND_CR) && (rx == CH_LF)) ||
	                   ((pend_q == PEND_LF) && (rx == CH_CR));
	assign room      = (fill_q < CNT_W'(BUFFER_DEPTH));
	assign fill_inc  = fill_q + CNT_W'(1);
	assign full_next = (fill_inc == CNT_W'(BUFFER_DEPTH));
	assign held_term = (held_byte_q == CH_CR) || (held_byte_q == CH_LF);

	// Decide whether this request flushes a line, and which line
	always_comb begin
		start_drain = 1'b0;
		start_defer = 1'b0;
		start_len   = fill_q;
		start_bin   = bin_q;
		if (accept) begin
			if (!is_byte) begin
				if (pend_q != PEND_NONE) begin
					start_drain = 1'b1;
				end else if ((fill_q != '0) && (idle_q == '0)) begin
					start_drain = 1'b1;
				end
			end else if ((pend_q != PEND_NONE) && partner && room) begin
				start_drain = 1'b1;
				start_len   = fill_inc;
				start_bin   = bin_q | rx[7];
			end else if (pend_q != PEND_NONE) begin
				start_drain = 1'b1;
				start_defer = 1'b1;
			end else if (full_next) begin
				start_drain = 1'b1;
				start_len   = fill_inc;
				start_bin   = bin_q | rx[7];
			end
		end
	end

	// Store bytes: at the fill position on request, at the line start after a drain
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = fill_q[IDX_W-1:0];
		mem_wdata = rx;
		if (state_q == ST_APPEND) begin
			mem_we    = 1'b1;
			mem_waddr = '0;
			mem_wdata = held_byte_q;
		end else if (accept && is_byte && room && !start_defer) begin
			mem_we = 1'b1;
		end
	end

	// Issue a read during a drain whenever the read stage can take it
	assign s1_move = rd_valid_s1 && (!out_valid_q || !out_stall);
	assign rd_en   = (state_q == ST_DRAIN) && (!rd_valid_s1 || s1_move);
	assign rd_last = ((rd_idx_q + CNT_W'(1)) == len_q);

	slf_line_mem #(
		.DEPTH (BUFFER_DEPTH),
		.IDX_W (IDX_W)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (rd_en),
		.raddr (rd_idx_q[IDX_W-1:0]),
		.rdata (rd_data)
	);

	// Sequencer state, line state and valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			fill_q      <= '0;
			bin_q       <= 1'b0;
			idle_q      <= '0;
			pend_q      <= PEND_NONE;
			timeout_q   <= TIMEOUT_RESET;
			rd_idx_q    <= '0;
			len_q       <= '0;
			len_bin_q   <= 1'b0;
			defer_q     <= 1'b0;
			rd_valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				timeout_q <= cfg_wdata;
			end

			case (state_q)
				ST_IDLE: begin
					if (start_drain) begin
						state_q   <= ST_DRAIN;
						rd_idx_q  <= '0;
						len_q     <= start_len;
						len_bin_q <= start_bin;
						defer_q   <= start_defer;
						fill_q    <= '0;
						bin_q     <= 1'b0;
						pend_q    <= PEND_NONE;
						if (is_byte && !start_defer) begin
							idle_q <= timeout_q;
						end
					end else if (accept && !is_byte) begin
						// count down the idle time of a partial line
						if (fill_q != '0) begin
							idle_q <= idle_q - 16'd1;
						end
					end else if (accept) begin
						fill_q <= fill_inc;
						bin_q  <= bin_q | rx[7];
						idle_q <= timeout_q;
						if (is_term) begin
							pend_q <= (rx == CH_CR) ? PEND_CR : PEND_LF;
						end
					end
				end
				ST_DRAIN: begin
					if (rd_en) begin
						rd_idx_q <= rd_idx_q + CNT_W'(1);
						if (rd_last) begin
							state_q <= defer_q ? ST_APPEND : ST_IDLE;
						end
					end
				end
				ST_APPEND: begin
					// the held byte opens a new line
					fill_q  <= CNT_W'(1);
					bin_q   <= held_byte_q[7];
					idle_q  <= timeout_q;
					if (held_term) begin
						pend_q <= (held_byte_q == CH_CR) ? PEND_CR : PEND_LF;
					end
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			// advance the read stage
			if (rd_en) begin
				rd_valid_s1 <= 1'b1;
			end else if (s1_move) begin
				rd_valid_s1 <= 1'b0;
			end

			// advance the output register
			if (s1_move) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers: held byte, read stage sideband, output
	always_ff @(posedge clk) begin
		if (start_defer) begin
			held_byte_q <= rx;
		end
		if (rd_en) begin
			rd_last_s1 <= rd_last;
			rd_bin_s1  <= len_bin_q;
		end
		if (s1_move) begin
			out_q.out_byte    <= rd_data;
			out_q.line_binary <= rd_bin_s1;
			out_q.last        <= rd_last_s1;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	`include "serial_line_framer_assert.svh"

	`SLF_ASSERT_NOW(a_fill_bound, clk, arst_n, 1'b1, fill_q < CNT_W'(BUFFER_DEPTH))
	`SLF_ASSERT_NOW(a_pend_nonempty, clk, arst_n, pend_q != PEND_NONE, fill_q != '0)
	`SLF_ASSERT_NOW(a_drain_in_line, clk, arst_n, state_q == ST_DRAIN, rd_idx_q < len_q)
	`SLF_ASSERT_NEXT(a_drain_empties, clk, arst_n, accept && start_drain, fill_q == '0)

endmodule
